FILE: rtl/lcd4_pkg.sv
package lcd4_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_BYTE = 2'd1,
    FUNC_INIT = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    REQ_NONE,
    REQ_BYTE,
    REQ_INIT
  } req_t;

  typedef struct packed {
    req_t       req;
    logic       rs;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [3:0] nib;
    logic       en;
    logic       rs;
  } pins_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_POWER,
    PH_INIT_EN,
    PH_INIT_OFF,
    PH_RS,
    PH_HI_EN,
    PH_HI_OFF,
    PH_LO_EN,
    PH_LO_OFF,
    PH_CLEAR
  } phase_t;

  localparam logic [7:0]  TICKS_PER_US_RESET = 8'd50;

  localparam logic [14:0] WAIT_POWER_US     = 15'd15000;
  localparam logic [14:0] WAIT_INIT_US      = 15'd5000;
  localparam logic [14:0] WAIT_INIT_LAST_US = 15'd1000;
  localparam logic [14:0] WAIT_RS_US        = 15'd100;
  localparam logic [14:0] WAIT_PULSE_US     = 15'd1;
  localparam logic [14:0] WAIT_SETTLE_US    = 15'd40;
  localparam logic [14:0] WAIT_CLEAR_US     = 15'd20000;

  localparam logic [3:0]  NIB_INIT      = 4'h3;
  localparam logic [3:0]  NIB_INIT_LAST = 4'h2;
  localparam logic [7:0]  CMD_CLEAR     = 8'h01;

  localparam logic [3:0]  STEP_NONE      = 4'd0;
  localparam logic [3:0]  STEP_FIRST_NIB = 4'd1;
  localparam logic [3:0]  STEP_LAST_NIB  = 4'd4;
  localparam logic [3:0]  STEP_CMD_FIRST = 4'd5;
  localparam logic [3:0]  STEP_CMD_LAST  = 4'd8;

  function automatic logic [7:0] init_cmd(input logic [1:0] idx);
    logic [7:0] cmd;
    unique case (idx)
      2'd0: cmd = 8'h28;
      2'd1: cmd = 8'h0C;
      2'd2: cmd = 8'h01;
      2'd3: cmd = 8'h06;
    endcase
    return cmd;
  endfunction

endpackage

FILE: rtl/lcd4_if.sv
interface lcd4_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic       rs;
  logic [7:0] data_byte;

  modport source (output valid, output func, output rs, output data_byte, input ready);
  modport sink (input valid, input func, input rs, input data_byte, output ready);
endinterface

interface lcd4_out_if;
  logic       valid;
  logic       ready;
  logic       lcd_rs;
  logic       lcd_enable;
  logic [3:0] lcd_data;
  logic       busy_res;
  logic       rejected;

  modport source (output valid, output lcd_rs, output lcd_enable, output lcd_data,
                  output busy_res, output rejected, input ready);
  modport sink (input valid, input lcd_rs, input lcd_enable, input lcd_data,
                input busy_res, input rejected, output ready);
endinterface

FILE: rtl/lcd4_front.sv
module lcd4_front (
  lcd4_in_if.sink         item,
  output logic            push_valid,
  input  logic            push_ready,
  output lcd4_pkg::item_t push_item
);

  assign push_valid = item.valid;
  assign item.ready = push_ready;

  // Sort the raw function code into a request kind; unused codes are plain ticks.
  always_comb begin
    push_item.rs        = item.rs;
    push_item.data_byte = item.data_byte;
    unique case (item.func)
      lcd4_pkg::FUNC_BYTE: push_item.req = lcd4_pkg::REQ_BYTE;
      lcd4_pkg::FUNC_INIT: push_item.req = lcd4_pkg::REQ_INIT;
      default:             push_item.req = lcd4_pkg::REQ_NONE;
    endcase
  end

endmodule

FILE: rtl/lcd4_queue.sv
module lcd4_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  lcd4_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output lcd4_pkg::item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lcd4_pkg::item_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/lcd4_back.sv
module lcd4_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata,
  input  logic            q_valid,
  output logic            q_ready,
  input  lcd4_pkg::item_t q_item,
  lcd4_out_if.source      result
);

  lcd4_pkg::phase_t phase, phase_next, enter_ph;
  logic [14:0]      us_countdown, cnt_next;
  logic [7:0]       tick_prescale, pre_next;
  logic [7:0]       byte_hold, byte_next;
  logic             rs_hold, rs_next;
  logic [3:0]       init_step, step_next;
  logic [3:0]       step_off;
  lcd4_pkg::pins_t  pins, pins_next;
  logic [7:0]       ticks_per_us;
  logic             pop;
  logic             do_enter;
  logic             finish;
  logic             rej;

  assign pop     = q_valid && (!result.valid || result.ready);
  assign q_ready = pop;
  assign step_off = init_step + 4'd1 - lcd4_pkg::STEP_CMD_FIRST;

  always_comb begin
    phase_next = phase;
    cnt_next   = us_countdown;
    pre_next   = tick_prescale;
    byte_next  = byte_hold;
    rs_next    = rs_hold;
    step_next  = init_step;
    pins_next  = pins;
    rej        = 1'b0;
    do_enter   = 1'b0;
    finish     = 1'b0;
    enter_ph   = lcd4_pkg::PH_IDLE;

    if (pop) begin
      if (phase != lcd4_pkg::PH_IDLE) begin
        rej = (q_item.req != lcd4_pkg::REQ_NONE);
        if (us_countdown != '0) begin
          if ({1'b0, tick_prescale} + 9'd1 >= {1'b0, ticks_per_us}) begin
            pre_next = '0;
            cnt_next = us_countdown - 15'd1;
          end else begin
            pre_next = tick_prescale + 8'd1;
          end
        end
        if (cnt_next == '0) begin
          do_enter = 1'b1;
          unique case (phase)
            lcd4_pkg::PH_POWER: begin
              step_next = lcd4_pkg::STEP_FIRST_NIB;
              enter_ph  = lcd4_pkg::PH_INIT_EN;
            end
            lcd4_pkg::PH_INIT_EN: enter_ph = lcd4_pkg::PH_INIT_OFF;
            lcd4_pkg::PH_INIT_OFF: begin
              if (init_step < lcd4_pkg::STEP_LAST_NIB) begin
                step_next = init_step + 4'd1;
                enter_ph  = lcd4_pkg::PH_INIT_EN;
              end else begin
                step_next = lcd4_pkg::STEP_CMD_FIRST;
                byte_next = lcd4_pkg::init_cmd(2'd0);
                rs_next   = 1'b0;
                enter_ph  = lcd4_pkg::PH_RS;
              end
            end
            lcd4_pkg::PH_RS:     enter_ph = lcd4_pkg::PH_HI_EN;
            lcd4_pkg::PH_HI_EN:  enter_ph = lcd4_pkg::PH_HI_OFF;
            lcd4_pkg::PH_HI_OFF: enter_ph = lcd4_pkg::PH_LO_EN;
            lcd4_pkg::PH_LO_EN:  enter_ph = lcd4_pkg::PH_LO_OFF;
            lcd4_pkg::PH_LO_OFF: begin
              // clear display needs the long extra wait
              if (!rs_hold && byte_hold == lcd4_pkg::CMD_CLEAR) begin
                enter_ph = lcd4_pkg::PH_CLEAR;
              end else begin
                finish = 1'b1;
              end
            end
            lcd4_pkg::PH_CLEAR: finish = 1'b1;
            default: begin
              step_next = lcd4_pkg::STEP_NONE;
              enter_ph  = lcd4_pkg::PH_IDLE;
            end
          endcase
          if (finish) begin
            // chain the next init command, or drop back to idle
            if (init_step >= lcd4_pkg::STEP_CMD_FIRST &&
                init_step < lcd4_pkg::STEP_CMD_LAST) begin
              step_next = init_step + 4'd1;
              byte_next = lcd4_pkg::init_cmd(step_off[1:0]);
              rs_next   = 1'b0;
              enter_ph  = lcd4_pkg::PH_RS;
            end else begin
              step_next = lcd4_pkg::STEP_NONE;
              enter_ph  = lcd4_pkg::PH_IDLE;
            end
          end
        end
      end else if (q_item.req == lcd4_pkg::REQ_BYTE) begin
        rs_next   = q_item.rs;
        byte_next = q_item.data_byte;
        step_next = lcd4_pkg::STEP_NONE;
        do_enter  = 1'b1;
        enter_ph  = lcd4_pkg::PH_RS;
      end else if (q_item.req == lcd4_pkg::REQ_INIT) begin
        step_next = lcd4_pkg::STEP_NONE;
        do_enter  = 1'b1;
        enter_ph  = lcd4_pkg::PH_POWER;
      end
    end

    if (do_enter) begin
      phase_next = enter_ph;
      pre_next   = '0;
      cnt_next   = '0;
      unique case (enter_ph)
        lcd4_pkg::PH_POWER: begin
          pins_next = '0;
          cnt_next  = lcd4_pkg::WAIT_POWER_US;
        end
        lcd4_pkg::PH_INIT_EN: begin
          pins_next.en  = 1'b1;
          pins_next.nib = (step_next >= lcd4_pkg::STEP_LAST_NIB) ?
                          lcd4_pkg::NIB_INIT_LAST : lcd4_pkg::NIB_INIT;
          cnt_next      = lcd4_pkg::WAIT_PULSE_US;
        end
        lcd4_pkg::PH_INIT_OFF: begin
          pins_next.en = 1'b0;
          cnt_next     = (step_next >= lcd4_pkg::STEP_LAST_NIB) ?
                         lcd4_pkg::WAIT_INIT_LAST_US : lcd4_pkg::WAIT_INIT_US;
        end
        lcd4_pkg::PH_RS: begin
          pins_next.rs = rs_next;
          pins_next.en = 1'b0;
          cnt_next     = lcd4_pkg::WAIT_RS_US;
        end
        lcd4_pkg::PH_HI_EN: begin
          pins_next.en  = 1'b1;
          pins_next.nib = byte_next[7:4];
          cnt_next      = lcd4_pkg::WAIT_PULSE_US;
        end
        lcd4_pkg::PH_HI_OFF: pins_next.en = 1'b0;
        lcd4_pkg::PH_LO_EN: begin
          pins_next.en  = 1'b1;
          pins_next.nib = byte_next[3:0];
          cnt_next      = lcd4_pkg::WAIT_PULSE_US;
        end
        lcd4_pkg::PH_LO_OFF: begin
          pins_next.en = 1'b0;
          cnt_next     = lcd4_pkg::WAIT_SETTLE_US;
        end
        lcd4_pkg::PH_CLEAR: cnt_next = lcd4_pkg::WAIT_CLEAR_US;
        default: cnt_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lcd4_pkg::PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      us_countdown  <= '0;
      tick_prescale <= '0;
      byte_hold     <= '0;
      rs_hold       <= 1'b0;
      init_step     <= lcd4_pkg::STEP_NONE;
      pins          <= '0;
      ticks_per_us  <= lcd4_pkg::TICKS_PER_US_RESET;
      result.valid  <= 1'b0;
    end else begin
      us_countdown  <= cnt_next;
      tick_prescale <= pre_next;
      byte_hold     <= byte_next;
      rs_hold       <= rs_next;
      init_step     <= step_next;
      pins          <= pins_next;
      if (cfg_we) begin
        ticks_per_us <= cfg_wdata;
      end
      if (pop) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // Result payload: hold while stalled.
  always_ff @(posedge clk) begin
    if (pop) begin
      result.lcd_rs     <= pins_next.rs;
      result.lcd_enable <= pins_next.en;
      result.lcd_data   <= pins_next.nib;
      result.busy_res   <= (phase_next != lcd4_pkg::PH_IDLE);
      result.rejected   <= rej;
    end
  end

  a_idle_no_wait : assert property (@(posedge clk) disable iff (rst)
    phase == lcd4_pkg::PH_IDLE |-> us_countdown == '0)
    else $error("countdown left running while idle");

  a_enable_phase : assert property (@(posedge clk) disable iff (rst)
    pins.en |-> (phase == lcd4_pkg::PH_INIT_EN || phase == lcd4_pkg::PH_HI_EN ||
                 phase == lcd4_pkg::PH_LO_EN))
    else $error("enable high outside a pulse phase");

  a_gap_one_tick : assert property (@(posedge clk) disable iff (rst)
    (pop && phase == lcd4_pkg::PH_HI_OFF) |=> phase == lcd4_pkg::PH_LO_EN)
    else $error("gap between nibbles longer than one tick");

  a_hold_on_stall : assert property (@(posedge clk) disable iff (rst)
    !pop |=> ($stable(phase) && $stable(us_countdown) && $stable(pins)))
    else $error("state moved without a tick");

endmodule

FILE: rtl/char_lcd_4bit_interface.sv
// A transferred item passes through the queue, then the result register, before its result shows.
// Throughput: one item per cycle while the result side is ready; the timing engine runs one tick per item.
// Delays are counted in items: N us take N*ticks_per_us ticks through the prescaler.
// Reset (rst, synchronous, active high): idle, pins low, queue empty, ticks_per_us = 50.
module char_lcd_4bit_interface #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  lcd4_in_if.sink    item,
  lcd4_out_if.source result
);

  logic            push_valid;
  logic            push_ready;
  lcd4_pkg::item_t push_item;
  logic            q_valid;
  logic            q_ready;
  lcd4_pkg::item_t q_item;

  lcd4_front u_front (
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  lcd4_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  lcd4_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .result    (result)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] FUNC_SPARE = 2'd3;   // unused code, acts as a plain tick
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT = 5000;
  localparam logic [7:0] SETUP_SEQ [0:3] = '{8'h28, 8'h0C, 8'h01, 8'h06};

  typedef struct packed {
    logic [1:0] func;
    logic       rs;
    logic [7:0] data;
  } lcd_req_t;

  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nib;
    logic       busy;
    logic       drop;
  } pin_sample_t;

  typedef struct packed {
    lcd4_pkg::phase_t ph;
    logic [14:0]      cnt;
    logic [7:0]       pre;
    logic [7:0]       byte_q;
    logic             rs_q;
    logic [3:0]       init_idx;
    lcd4_pkg::pins_t  pins;
  } lcd_seq_t;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  lcd4_in_if  in_ch();
  lcd4_out_if out_ch();

  char_lcd_4bit_interface dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item     (in_ch),
    .result   (out_ch)
  );

  lcd_req_t    req_q[$];
  pin_sample_t pin_levels_q[$];
  lcd_seq_t    seq_state;
  logic [7:0]  us_ticks;
  logic        step_drop;
  lcd_req_t    drv_next;
  pin_sample_t seen, want;

  int n_pushed, n_accepted, n_checked, n_fail;
  int n_bytes, n_dropped;
  int burst_left, gap_left;
  int quiet_cycles;
  int rx_left, rx_tick;
  rx_mode_t rx_mode;

  // ---------------------------------------------------------------------------
  // Timing predictor
  // ---------------------------------------------------------------------------
  function automatic lcd_seq_t enter_phase(input lcd_seq_t s, input lcd4_pkg::phase_t p);
    logic [14:0] hold_us;
    hold_us = '0;
    s.ph = p;
    s.pre = '0;
    case (p)
      lcd4_pkg::PH_POWER: begin
        s.pins = '0;
        hold_us = lcd4_pkg::WAIT_POWER_US;
      end
      lcd4_pkg::PH_INIT_EN: begin
        s.pins.en = 1'b1;
        s.pins.nib = (s.init_idx >= lcd4_pkg::STEP_LAST_NIB) ?
                     lcd4_pkg::NIB_INIT_LAST : lcd4_pkg::NIB_INIT;
        hold_us = lcd4_pkg::WAIT_PULSE_US;
      end
      lcd4_pkg::PH_INIT_OFF: begin
        s.pins.en = 1'b0;
        hold_us = (s.init_idx >= lcd4_pkg::STEP_LAST_NIB) ?
                  lcd4_pkg::WAIT_INIT_LAST_US : lcd4_pkg::WAIT_INIT_US;
      end
      lcd4_pkg::PH_RS: begin
        s.pins.rs = s.rs_q;
        s.pins.en = 1'b0;
        hold_us = lcd4_pkg::WAIT_RS_US;
      end
      lcd4_pkg::PH_HI_EN: begin
        s.pins.en = 1'b1;
        s.pins.nib = s.byte_q[7:4];
        hold_us = lcd4_pkg::WAIT_PULSE_US;
      end
      lcd4_pkg::PH_HI_OFF: s.pins.en = 1'b0;
      lcd4_pkg::PH_LO_EN: begin
        s.pins.en = 1'b1;
        s.pins.nib = s.byte_q[3:0];
        hold_us = lcd4_pkg::WAIT_PULSE_US;
      end
      lcd4_pkg::PH_LO_OFF: begin
        s.pins.en = 1'b0;
        hold_us = lcd4_pkg::WAIT_SETTLE_US;
      end
      lcd4_pkg::PH_CLEAR: hold_us = lcd4_pkg::WAIT_CLEAR_US;
      default: s.ph = lcd4_pkg::PH_IDLE;
    endcase
    s.cnt = hold_us;
    return s;
  endfunction

  // After a byte: either queue the next setup command or drop back to idle.
  function automatic lcd_seq_t close_byte(input lcd_seq_t s);
    logic [3:0] off;
    if (s.init_idx >= lcd4_pkg::STEP_CMD_FIRST && s.init_idx < lcd4_pkg::STEP_CMD_LAST) begin
      s.init_idx = s.init_idx + 4'd1;
      off = s.init_idx - lcd4_pkg::STEP_CMD_FIRST;
      s.byte_q = SETUP_SEQ[off[1:0]];
      s.rs_q = 1'b0;
      s = enter_phase(s, lcd4_pkg::PH_RS);
    end else begin
      s.init_idx = lcd4_pkg::STEP_NONE;
      s = enter_phase(s, lcd4_pkg::PH_IDLE);
    end
    return s;
  endfunction

  function automatic lcd_seq_t advance_phase(input lcd_seq_t s);
    case (s.ph)
      lcd4_pkg::PH_POWER: begin
        s.init_idx = lcd4_pkg::STEP_FIRST_NIB;
        s = enter_phase(s, lcd4_pkg::PH_INIT_EN);
      end
      lcd4_pkg::PH_INIT_EN: s = enter_phase(s, lcd4_pkg::PH_INIT_OFF);
      lcd4_pkg::PH_INIT_OFF: begin
        if (s.init_idx < lcd4_pkg::STEP_LAST_NIB) begin
          s.init_idx = s.init_idx + 4'd1;
          s = enter_phase(s, lcd4_pkg::PH_INIT_EN);
        end else begin
          s.init_idx = lcd4_pkg::STEP_CMD_FIRST;
          s.byte_q = SETUP_SEQ[0];
          s.rs_q = 1'b0;
          s = enter_phase(s, lcd4_pkg::PH_RS);
        end
      end
      lcd4_pkg::PH_RS:     s = enter_phase(s, lcd4_pkg::PH_HI_EN);
      lcd4_pkg::PH_HI_EN:  s = enter_phase(s, lcd4_pkg::PH_HI_OFF);
      lcd4_pkg::PH_HI_OFF: s = enter_phase(s, lcd4_pkg::PH_LO_EN);
      lcd4_pkg::PH_LO_EN:  s = enter_phase(s, lcd4_pkg::PH_LO_OFF);
      lcd4_pkg::PH_LO_OFF: begin
        if (!s.rs_q && s.byte_q == lcd4_pkg::CMD_CLEAR) s = enter_phase(s, lcd4_pkg::PH_CLEAR);
        else s = close_byte(s);
      end
      lcd4_pkg::PH_CLEAR: s = close_byte(s);
      default: begin
        s.init_idx = lcd4_pkg::STEP_NONE;
        s = enter_phase(s, lcd4_pkg::PH_IDLE);
      end
    endcase
    return s;
  endfunction

  function automatic lcd_seq_t lcd_timing_step(input lcd_seq_t s, input logic [1:0] func,
                                               input logic rs_in, input logic [7:0] byte_in,
                                               input logic [7:0] rate, output logic drop);
    logic req;
    req = (func == lcd4_pkg::FUNC_BYTE) || (func == lcd4_pkg::FUNC_INIT);
    drop = 1'b0;
    if (s.ph != lcd4_pkg::PH_IDLE) begin
      drop = req;
      if (s.cnt != '0) begin
        // a rate of zero still ends every microsecond after one tick
        if ({1'b0, s.pre} + 9'd1 >= {1'b0, rate}) begin
          s.pre = '0;
          s.cnt = s.cnt - 15'd1;
        end else begin
          s.pre = s.pre + 8'd1;
        end
      end
      if (s.cnt == '0) s = advance_phase(s);
    end else if (func == lcd4_pkg::FUNC_BYTE) begin
      s.rs_q = rs_in;
      s.byte_q = byte_in;
      s.init_idx = lcd4_pkg::STEP_NONE;
      s = enter_phase(s, lcd4_pkg::PH_RS);
    end else if (func == lcd4_pkg::FUNC_INIT) begin
      s.init_idx = lcd4_pkg::STEP_NONE;
      s = enter_phase(s, lcd4_pkg::PH_POWER);
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, driver, receiver, checker
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.func = lcd4_pkg::FUNC_TICK;
    in_ch.rs = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      seq_state = '0;
      us_ticks = lcd4_pkg::TICKS_PER_US_RESET;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (seq_state.ph == lcd4_pkg::PH_IDLE && in_ch.func == lcd4_pkg::FUNC_BYTE) n_bytes++;
        seq_state = lcd_timing_step(seq_state, in_ch.func, in_ch.rs, in_ch.data_byte,
                                    us_ticks, step_drop);
        if (step_drop) n_dropped++;
        pin_levels_q.push_back('{rs: seq_state.pins.rs, en: seq_state.pins.en,
                                 nib: seq_state.pins.nib,
                                 busy: seq_state.ph != lcd4_pkg::PH_IDLE,
                                 drop: step_drop});
        n_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (req_q.size() != 0) begin
          drv_next = req_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func <= drv_next.func;
          in_ch.rs <= drv_next.rs;
          in_ch.data_byte <= drv_next.data;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_mode = RX_OPEN;
      rx_left = 0;
      rx_tick = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(50, 400);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:     out_ch.ready <= 1'b1;
        RX_LIGHT:    out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_ch.ready <= (rx_tick % 3 != 0);
        default:     out_ch.ready <= ($urandom_range(0, 4) < 2);
      endcase
    end
  end

  task automatic flag_error(input string msg);
    n_fail++;
    if (n_fail <= 10) $display("ERROR: %s", msg);
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen = '{rs: out_ch.lcd_rs, en: out_ch.lcd_enable, nib: out_ch.lcd_data,
               busy: out_ch.busy_res, drop: out_ch.rejected};
      if (pin_levels_q.size() == 0) begin
        flag_error($sformatf("unexpected result rs=%b en=%b data=%h busy=%b rejected=%b",
                             seen.rs, seen.en, seen.nib, seen.busy, seen.drop));
      end else begin
        want = pin_levels_q.pop_front();
        if (seen.rs !== want.rs || seen.en !== want.en || seen.nib !== want.nib ||
            seen.busy !== want.busy || seen.drop !== want.drop)
          flag_error($sformatf({"result %0d: expected rs=%b en=%b data=%h busy=%b rejected=%b,",
                                " got rs=%b en=%b data=%h busy=%b rejected=%b"}, n_checked,
                               want.rs, want.en, want.nib, want.busy, want.drop,
                               seen.rs, seen.en, seen.nib, seen.busy, seen.drop));
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push(input lcd_req_t r);
    req_q.push_back(r);
    n_pushed++;
  endtask

  // Tick content: plain ticks, or with noisy set some requests that must be dropped.
  function automatic lcd_req_t filler(input bit noisy);
    lcd_req_t r;
    r.rs = 1'($urandom_range(0, 1));
    r.data = 8'($urandom);
    if (noisy && $urandom_range(0, 9) >= 7) r.func = 2'($urandom_range(1, 3));
    else if ($urandom_range(0, 1) != 0) r.func = FUNC_SPARE;
    else r.func = lcd4_pkg::FUNC_TICK;
    return r;
  endfunction

  task automatic idle_ticks(input int n);
    repeat (n) push(filler(1'b0));
    wait (n_accepted == n_pushed);
  endtask

  // Fixed run of ticks; only safe while the block is known to stay busy throughout.
  task automatic feed(input int n, input bit noisy);
    repeat (n) push(filler(noisy));
    wait (n_accepted == n_pushed);
  endtask

  // Feed ticks until the predicted sequence is back to idle. Batches stay inside
  // the current phase; near its end step one tick at a time.
  task automatic run_out(input bit noisy);
    lcd_seq_t peek;
    logic peek_drop;
    lcd_req_t r;
    int eff, lb, n;
    while (seq_state.ph != lcd4_pkg::PH_IDLE) begin
      eff = (us_ticks == 8'd0) ? 1 : int'(us_ticks);
      lb = (seq_state.cnt == '0) ? 0 : (int'(seq_state.cnt) - 1) * eff;
      n = (lb >= 64) ? 64 : ((lb >= 16) ? 16 : 0);
      if (n > 0) begin
        repeat (n) push(filler(noisy));
      end else begin
        peek = lcd_timing_step(seq_state, lcd4_pkg::FUNC_TICK, 1'b0, 8'h00, us_ticks,
                               peek_drop);
        r = filler(noisy);
        // a request on the very last busy tick is still dropped
        if (noisy && peek.ph == lcd4_pkg::PH_IDLE) r.func = 2'($urandom_range(1, 2));
        push(r);
      end
      wait (n_accepted == n_pushed);
    end
  endtask

  task automatic send_byte(input logic rs, input logic [7:0] d, input bit noisy);
    push('{func: lcd4_pkg::FUNC_BYTE, rs: rs, data: d});
    wait (n_accepted == n_pushed);
    run_out(noisy);
  endtask

  task automatic set_rate(input logic [7:0] v);
    wait (n_accepted == n_pushed && n_checked == n_accepted);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    us_ticks = v;
  endtask

  task automatic random_bytes(input int n);
    logic rs;
    logic [7:0] d;
    repeat (n) begin
      idle_ticks($urandom_range(0, 3));
      rs = 1'($urandom_range(0, 1));
      d = 8'($urandom);
      if (!rs && d == lcd4_pkg::CMD_CLEAR) begin
        // keep the long clear wait out of random traffic
        d = d ^ 8'h80;
      end
      send_byte(rs, d, $urandom_range(0, 4) != 0);
    end
  endtask

  initial begin
    n_pushed = 0;
    n_accepted = 0;
    n_checked = 0;
    n_fail = 0;
    n_bytes = 0;
    n_dropped = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // idle: pins stay low, spare code does nothing
    push('{func: lcd4_pkg::FUNC_TICK, rs: 1'b1, data: 8'hFF});
    push('{func: FUNC_SPARE, rs: 1'b0, data: 8'h00});
    push('{func: FUNC_SPARE, rs: 1'b1, data: 8'hFF});
    wait (n_accepted == n_pushed);

    // power-on rate, then a lower rate mid-wait: a prescale count already past
    // the new rate ends the current microsecond at once
    push('{func: lcd4_pkg::FUNC_BYTE, rs: 1'b1, data: 8'hA5});
    feed(120, 1'b1);
    set_rate(8'd2);
    run_out(1'b1);
    idle_ticks(2);

    // top rate: let the prescaler run to its limit, then speed up mid-wait
    set_rate(8'd255);
    push('{func: lcd4_pkg::FUNC_BYTE, rs: 1'b0, data: 8'h5A});
    feed(300, 1'b1);
    set_rate(8'd1);
    run_out(1'b1);

    send_byte(1'b0, 8'h00, 1'b1);
    send_byte(1'b1, 8'hFF, 1'b0);
    idle_ticks(2);
    send_byte(1'b1, lcd4_pkg::CMD_CLEAR, 1'b1);

    set_rate(8'd0);
    send_byte(1'b0, 8'h3C, 1'b1);

    set_rate(8'd1);
    random_bytes(2);

    // clear command: enter the long clear wait and stop partway through it
    push('{func: lcd4_pkg::FUNC_BYTE, rs: 1'b0, data: lcd4_pkg::CMD_CLEAR});
    feed(150, 1'b1);

    wait (n_accepted == n_pushed && n_checked == n_accepted);
    repeat (12) @(posedge clk);
    if (pin_levels_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", pin_levels_q.size()));
    $display("Checked %0d tick results: %0d byte sends, %0d dropped requests",
             n_checked, n_bytes, n_dropped);
    $display("Rates 0, 1, 2, 50 and 255 with mid-wait changes, ending in clear wait; %0d bad",
             n_fail);
    if (n_fail == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lcd4_pkg.sv
rtl/lcd4_if.sv
rtl/lcd4_front.sv
rtl/lcd4_queue.sv
rtl/lcd4_back.sv
rtl/char_lcd_4bit_interface.sv
tb/tb.sv
